FILE: rtl/nfccfb_pkg.sv
package nfccfb_pkg;

  localparam logic [9:0] NORMAL_MAX_LEN    = 10'd254;
  localparam logic [9:0] EXTENDED_MAX_LEN  = 10'd264;
  localparam logic [10:0] NORMAL_OVERHEAD   = 11'd8;
  localparam logic [10:0] EXTENDED_OVERHEAD = 11'd11;

  localparam logic [7:0] TFI_HOST   = 8'hD4;
  localparam logic [7:0] DCS_INIT   = 8'h2C;
  localparam logic [7:0] EXT_MARK   = 8'hFF;
  localparam logic [7:0] POSTAMBLE  = 8'h00;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_TOO_LONG = 1'b1;

  // longest run of frame bytes one request can cause (extended header)
  localparam int BURST_MAX = 6;
  localparam int IDX_W     = $clog2(BURST_MAX);
  localparam int CNT_W     = $clog2(BURST_MAX + 1);

  typedef struct packed {
    logic       cmd;
    logic [9:0] payload_length;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last;
    logic        status;
    logic [10:0] frame_size;
  } result_t;

  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [CNT_W-1:0]          count;
    logic                      last;
    logic                      status;
    logic [10:0]               frame_size;
  } burst_t;

  typedef struct packed {
    logic       open;
    logic [9:0] left;
    logic [7:0] checksum;
  } frame_state_t;

endpackage

FILE: rtl/nfccfb_if.sv
interface nfccfb_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/nfccfb_encoder.sv
module nfccfb_encoder (
  input  nfccfb_pkg::item_t        item,
  input  nfccfb_pkg::frame_state_t state,
  output nfccfb_pkg::burst_t       burst,
  output nfccfb_pkg::frame_state_t state_next
);

  logic [10:0] lenp1;
  logic [7:0]  len_hi;
  logic [7:0]  len_lo;
  logic [7:0]  cs_next;
  logic [9:0]  left_next;

  assign lenp1     = {1'b0, item.payload_length} + 11'd1;
  assign len_hi    = {5'd0, lenp1[10:8]};
  assign len_lo    = lenp1[7:0];
  assign cs_next   = state.checksum - item.data_byte;
  assign left_next = state.left - 10'd1;

  always_comb begin
    burst      = '0;
    state_next = state;
    if (item.cmd == nfccfb_pkg::CMD_START) begin
      state_next.open     = 1'b0;
      state_next.left     = '0;
      state_next.checksum = nfccfb_pkg::DCS_INIT;
      if (item.payload_length <= nfccfb_pkg::NORMAL_MAX_LEN) begin
        burst.frame_size = {1'b0, item.payload_length} + nfccfb_pkg::NORMAL_OVERHEAD;
        burst.bytes[0]   = len_lo;
        burst.bytes[1]   = 8'd0 - len_lo;
        burst.bytes[2]   = nfccfb_pkg::TFI_HOST;
        if (item.payload_length == '0) begin
          // empty frame: trailer follows the header at once
          burst.bytes[3] = nfccfb_pkg::DCS_INIT;
          burst.bytes[4] = nfccfb_pkg::POSTAMBLE;
          burst.count    = nfccfb_pkg::CNT_W'(5);
          burst.last     = 1'b1;
        end else begin
          burst.count     = nfccfb_pkg::CNT_W'(3);
          state_next.open = 1'b1;
          state_next.left = item.payload_length;
        end
      end else if (item.payload_length <= nfccfb_pkg::EXTENDED_MAX_LEN) begin
        burst.frame_size = {1'b0, item.payload_length} + nfccfb_pkg::EXTENDED_OVERHEAD;
        burst.bytes[0]   = nfccfb_pkg::EXT_MARK;
        burst.bytes[1]   = nfccfb_pkg::EXT_MARK;
        burst.bytes[2]   = len_hi;
        burst.bytes[3]   = len_lo;
        burst.bytes[4]   = 8'd0 - (len_hi + len_lo);
        burst.bytes[5]   = nfccfb_pkg::TFI_HOST;
        burst.count      = nfccfb_pkg::CNT_W'(6);
        state_next.open  = 1'b1;
        state_next.left  = item.payload_length;
      end else begin
        burst.count         = nfccfb_pkg::CNT_W'(1);
        burst.last          = 1'b1;
        burst.status        = nfccfb_pkg::STATUS_TOO_LONG;
        state_next.checksum = '0;
      end
    end else if (state.open) begin
      burst.bytes[0]      = item.data_byte;
      state_next.checksum = cs_next;
      state_next.left     = left_next;
      if (left_next == '0) begin
        burst.bytes[1]  = cs_next;
        burst.bytes[2]  = nfccfb_pkg::POSTAMBLE;
        burst.count     = nfccfb_pkg::CNT_W'(3);
        burst.last      = 1'b1;
        state_next.open = 1'b0;
      end else begin
        burst.count = nfccfb_pkg::CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/nfccfb_emitter.sv
module nfccfb_emitter (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  nfccfb_pkg::burst_t  burst_in,
  output logic                can_load,
  nfccfb_if.source            frame
);

  nfccfb_pkg::burst_t                 burst;
  logic                               loaded;
  logic [nfccfb_pkg::IDX_W-1:0]       idx;
  logic                               take;
  logic                               final_byte;
  nfccfb_pkg::result_t                res;

  assign take       = loaded && frame.ready;
  assign final_byte = (nfccfb_pkg::CNT_W'(idx) == (burst.count - nfccfb_pkg::CNT_W'(1)));
  assign can_load   = !loaded || (take && final_byte);

  always_comb begin
    res            = '0;
    res.out_byte   = burst.bytes[idx];
    res.last       = burst.last && final_byte;
    res.status     = burst.status;
    res.frame_size = burst.frame_size;
  end

  assign frame.valid   = loaded;
  assign frame.payload = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 1'b0;
      idx    <= '0;
    end else if (load) begin
      // a request that causes no byte just lets the current run drain
      loaded <= (burst_in.count != '0);
      idx    <= '0;
    end else if (take) begin
      if (final_byte) begin
        loaded <= 1'b0;
      end else begin
        idx <= idx + nfccfb_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst <= burst_in;
    end
  end

endmodule

FILE: rtl/nfc_command_frame_builder.sv
// Information frame encoder: takes a start request carrying the payload length and then one
// request per payload byte, and returns the frame from the LEN byte (extended frame: from its
// two FF markers) on, one byte per result (preamble not included). A payload byte gives one
// result; a start gives 3 (short frame), 6 (extended frame) or 5 (empty frame), and the
// final payload byte gives 3. The input waits meanwhile, since the output sequencer sends one
// frame byte per cycle unless the output stalls, and takes the next request in the cycle its
// last byte is taken. A length above 264 gives a single result with status and last set. A
// start abandons any open frame; payload bytes outside a frame are dropped without a result.
module nfc_command_frame_builder (
  input  logic     clk,
  input  logic     rst,
  nfccfb_if.sink   host,
  nfccfb_if.source frame
);

  nfccfb_pkg::frame_state_t state;
  nfccfb_pkg::frame_state_t state_next;
  nfccfb_pkg::burst_t       burst;
  logic                     can_load;
  logic                     accept;

  nfccfb_encoder u_encoder (
    .item       (host.payload),
    .state      (state),
    .burst      (burst),
    .state_next (state_next)
  );

  nfccfb_emitter u_emitter (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .burst_in (burst),
    .can_load (can_load),
    .frame    (frame)
  );

  assign host.ready = can_load;
  assign accept     = host.valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/nfccfb_checker.sv
module nfccfb_checker (
  input logic        clk,
  input logic        rst,
  input logic        host_valid,
  input logic        host_ready,
  input logic        frame_valid,
  input logic        frame_ready,
  input logic [7:0]  out_byte,
  input logic        last,
  input logic        status,
  input logic [10:0] frame_size
);

  // error result is a single closing result with zeroed fields
  a_error_form: assert property (@(posedge clk) disable iff (rst)
    frame_valid && status |-> last && out_byte == 8'd0 && frame_size == 11'd0)
    else $error("error result malformed");

  // a stalled output byte blocks new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_ready |-> !host_ready)
    else $error("request taken while output stalled");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !frame_valid |-> host_ready)
    else $error("idle block refuses requests");

  // a request only lands while the pending byte is taken as well
  a_take_on_handover: assert property (@(posedge clk) disable iff (rst)
    host_valid && host_ready && frame_valid |-> frame_ready)
    else $error("request taken over a waiting byte");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !frame_valid)
    else $error("output valid right after reset");

endmodule

bind nfc_command_frame_builder nfccfb_checker u_nfccfb_checker (
  .clk         (clk),
  .rst         (rst),
  .host_valid  (host.valid),
  .host_ready  (host.ready),
  .frame_valid (frame.valid),
  .frame_ready (frame.ready),
  .out_byte    (frame.payload.out_byte),
  .last        (frame.payload.last),
  .status      (frame.payload.status),
  .frame_size  (frame.payload.frame_size)
);
